FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BTS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bts_pkg.sv
package bts_pkg;

    localparam int MAX_DIM_DEF     = 256;
    localparam int TEXEL_DEPTH_DEF = 65536;
    localparam int WEIGHT_BITS_DEF = 8;

    localparam int DIM_REG_W = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CHAN_W    = 8;
    localparam int TEXEL_W   = 3 * CHAN_W;
    localparam int ADDR_IN_W = 16;
    localparam int COORD_W   = 24;
    localparam int FRAC_W    = 16;
    localparam int OUT_W     = 16;
    localparam logic [FRAC_W:0] ONE_Q16 = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_WIDTH     = 2'd0,
        CFG_TEX_HEIGHT    = 2'd1,
        CFG_TEXTURE_READY = 2'd2
    } bts_cfg_idx_t;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } bts_cmd_t;

    typedef struct packed {
        logic                        cmd;
        logic [ADDR_IN_W-1:0]        texel_addr;
        logic [CHAN_W-1:0]           texel_red;
        logic [CHAN_W-1:0]           texel_green;
        logic [CHAN_W-1:0]           texel_blue;
        logic signed [COORD_W-1:0]   coord_u;
        logic signed [COORD_W-1:0]   coord_v;
    } bts_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] out_red;
        logic [OUT_W-1:0] out_green;
        logic [OUT_W-1:0] out_blue;
    } bts_out_t;

    typedef struct packed {
        logic valid;
        logic sample;
        logic wr_ok;
    } bts_ctl_t;

endpackage

FILE: rtl/bts_ram.sv
module bts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: rtl/bts_addr.sv
module bts_addr #(
    parameter int MAX_DIM     = bts_pkg::MAX_DIM_DEF,
    parameter int TEXEL_DEPTH = bts_pkg::TEXEL_DEPTH_DEF,
    parameter int WEIGHT_BITS = bts_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  adv,
    input  logic                                  s_valid,
    input  bts_pkg::bts_in_t                      s_data,
    input  logic [bts_pkg::DIM_REG_W-1:0]         tex_width,
    input  logic [bts_pkg::DIM_REG_W-1:0]         tex_height,
    output bts_pkg::bts_ctl_t                     ctl5,
    output logic [3:0][$clog2(TEXEL_DEPTH)-1:0]   raddr5,
    output logic [$clog2(TEXEL_DEPTH)-1:0]        waddr5,
    output logic [bts_pkg::TEXEL_W-1:0]           texel5,
    output logic [WEIGHT_BITS-1:0]                fu5,
    output logic [WEIGHT_BITS-1:0]                fv5
);

    localparam int DIMW = $clog2(MAX_DIM);
    localparam int DW   = $clog2(MAX_DIM + 1);
    localparam int IDXW = $clog2(MAX_DIM * MAX_DIM);
    localparam int AW   = $clog2(TEXEL_DEPTH);
    localparam int RS   = IDXW + AW;
    localparam int RCW  = IDXW + 2;
    localparam int PW   = bts_pkg::FRAC_W + 1 + DIMW;
    localparam longint unsigned RECIP =
        ((64'd1 << RS) + 64'(TEXEL_DEPTH) - 64'd1) / 64'(TEXEL_DEPTH);

    function automatic logic [bts_pkg::FRAC_W:0] wrap_coord(
        input logic signed [bts_pkg::COORD_W-1:0] c
    );
        logic [bts_pkg::COORD_W-1:0] neg;
        logic [bts_pkg::FRAC_W:0]    res;
        neg = -c;
        if (c[bts_pkg::COORD_W-1]) begin
            res = bts_pkg::ONE_Q16 - {1'b0, neg[bts_pkg::FRAC_W-1:0]};
        end else if (c <= $signed({7'd0, bts_pkg::ONE_Q16})) begin
            res = c[bts_pkg::FRAC_W:0];
        end else begin
            res = {1'b0, c[bts_pkg::FRAC_W-1:0]};
        end
        return res;
    endfunction

    logic [DW-1:0]   w_c;
    logic [DW-1:0]   h_c;
    logic [DIMW-1:0] wm1;
    logic [DIMW-1:0] hm1;

    always_comb begin
        if (tex_width == '0) begin
            w_c = DW'(1);
        end else if (32'(tex_width) > 32'(MAX_DIM)) begin
            w_c = DW'(MAX_DIM);
        end else begin
            w_c = DW'(tex_width);
        end
        if (tex_height == '0) begin
            h_c = DW'(1);
        end else if (32'(tex_height) > 32'(MAX_DIM)) begin
            h_c = DW'(MAX_DIM);
        end else begin
            h_c = DW'(tex_height);
        end
        wm1 = DIMW'(w_c - DW'(1));
        hm1 = DIMW'(h_c - DW'(1));
    end

    bts_pkg::bts_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    logic [bts_pkg::FRAC_W:0]  tu1_reg, tv1_reg;
    logic [bts_pkg::TEXEL_W-1:0] tx1_reg, tx2_reg, tx3_reg, tx4_reg, tx5_reg;
    logic [AW-1:0]             wa1_reg, wa2_reg, wa3_reg, wa4_reg, wa5_reg;
    logic [DIMW-1:0]           x2_reg, y2_reg;
    logic [WEIGHT_BITS-1:0]    fu2_reg, fv2_reg, fu3_reg, fv3_reg;
    logic [WEIGHT_BITS-1:0]    fu4_reg, fv4_reg, fu5_reg, fv5_reg;
    logic [3:0][IDXW-1:0]      idx3_reg, idx4_reg;
    logic [3:0][IDXW-1:0]      q4_reg;
    logic [3:0][AW-1:0]        ra5_reg;

    bts_pkg::bts_ctl_t    ctl1_next;
    logic [PW-1:0]        pu, pv;
    logic [DW-1:0]        xp1, yp1;
    logic                 r_ok, d_ok;
    logic [IDXW-1:0]      base;
    logic [3:0][IDXW-1:0] idx3_next;
    logic [3:0][IDXW-1:0] q4_next;
    logic [3:0][AW-1:0]   ra5_next;

    always_comb begin
        ctl1_next.valid  = s_valid;
        ctl1_next.sample = (s_data.cmd == bts_pkg::CMD_SAMPLE);
        ctl1_next.wr_ok  = 32'(s_data.texel_addr) < 32'(TEXEL_DEPTH);

        pu = PW'(tu1_reg) * PW'(wm1);
        pv = PW'(tv1_reg) * PW'(hm1);

        xp1  = DW'(x2_reg) + DW'(1);
        yp1  = DW'(y2_reg) + DW'(1);
        r_ok = xp1 < w_c;
        d_ok = yp1 < h_c;
        base = IDXW'(y2_reg) * IDXW'(w_c) + IDXW'(x2_reg);
        idx3_next[0] = base;
        idx3_next[1] = r_ok ? base + IDXW'(1) : base;
        idx3_next[2] = d_ok ? base + IDXW'(w_c) : base;
        idx3_next[3] = (r_ok && d_ok) ? base + IDXW'(w_c) + IDXW'(1) : base;

        for (int k = 0; k < 4; k++) begin
            q4_next[k]  = IDXW'(((IDXW + RCW)'(idx3_reg[k]) * (IDXW + RCW)'(RECIP)) >> RS);
            ra5_next[k] = AW'(64'(idx4_reg[k]) - 64'(q4_reg[k]) * 64'(TEXEL_DEPTH));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end else if (adv) begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tu1_reg  <= wrap_coord(s_data.coord_u);
            tv1_reg  <= wrap_coord(s_data.coord_v);
            tx1_reg  <= {s_data.texel_red, s_data.texel_green, s_data.texel_blue};
            wa1_reg  <= AW'(s_data.texel_addr);

            x2_reg   <= pu[bts_pkg::FRAC_W +: DIMW];
            y2_reg   <= pv[bts_pkg::FRAC_W +: DIMW];
            fu2_reg  <= pu[bts_pkg::FRAC_W-1 -: WEIGHT_BITS];
            fv2_reg  <= pv[bts_pkg::FRAC_W-1 -: WEIGHT_BITS];
            tx2_reg  <= tx1_reg;
            wa2_reg  <= wa1_reg;

            idx3_reg <= idx3_next;
            fu3_reg  <= fu2_reg;
            fv3_reg  <= fv2_reg;
            tx3_reg  <= tx2_reg;
            wa3_reg  <= wa2_reg;

            q4_reg   <= q4_next;
            idx4_reg <= idx3_reg;
            fu4_reg  <= fu3_reg;
            fv4_reg  <= fv3_reg;
            tx4_reg  <= tx3_reg;
            wa4_reg  <= wa3_reg;

            ra5_reg  <= ra5_next;
            fu5_reg  <= fu4_reg;
            fv5_reg  <= fv4_reg;
            tx5_reg  <= tx4_reg;
            wa5_reg  <= wa4_reg;
        end
    end

    assign ctl5   = ctl5_reg;
    assign raddr5 = ra5_reg;
    assign waddr5 = wa5_reg;
    assign texel5 = tx5_reg;
    assign fu5    = fu5_reg;
    assign fv5    = fv5_reg;

endmodule

FILE: rtl/bts_blend.sv
module bts_blend #(
    parameter int WEIGHT_BITS = bts_pkg::WEIGHT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  logic                               tex_ready,
    input  bts_pkg::bts_ctl_t                  ctl5,
    input  logic [WEIGHT_BITS-1:0]             fu5,
    input  logic [WEIGHT_BITS-1:0]             fv5,
    input  logic [3:0][bts_pkg::TEXEL_W-1:0]   rdata,
    output logic                               res_valid,
    output bts_pkg::bts_out_t                  res_data
);

    localparam int CW = bts_pkg::CHAN_W;
    localparam int WW = WEIGHT_BITS + 1;
    localparam int TW = CW + WEIGHT_BITS + 1;
    localparam int RW = CW + 2 * WEIGHT_BITS + 2;
    localparam int SH = 2 * WEIGHT_BITS - 8;
    localparam logic [WW-1:0] WMAX = WW'(1) << WEIGHT_BITS;

    bts_pkg::bts_ctl_t ctl6_reg, ctl7_reg, ctl8_reg;
    logic [WEIGHT_BITS-1:0] fu6_reg, fv6_reg, fv7_reg;
    logic [2:0][TW-1:0]     top7_reg, bot7_reg;
    bts_pkg::bts_out_t      out8_reg;

    logic [2:0][TW-1:0]     top_next, bot_next;
    logic [2:0][RW-1:0]     mix;
    bts_pkg::bts_out_t      out_next;
    logic [WW-1:0]          fu_w, fu_c, fv_w, fv_c;

    always_comb begin
        fu_w = WW'(fu6_reg);
        fu_c = WMAX - fu_w;
        fv_w = WW'(fv7_reg);
        fv_c = WMAX - fv_w;
        for (int c = 0; c < 3; c++) begin
            top_next[c] = TW'(rdata[0][CW*(2-c) +: CW]) * TW'(fu_c)
                        + TW'(rdata[1][CW*(2-c) +: CW]) * TW'(fu_w);
            bot_next[c] = TW'(rdata[2][CW*(2-c) +: CW]) * TW'(fu_c)
                        + TW'(rdata[3][CW*(2-c) +: CW]) * TW'(fu_w);
            mix[c] = RW'(top7_reg[c]) * RW'(fv_c) + RW'(bot7_reg[c]) * RW'(fv_w);
        end
        if (tex_ready) begin
            out_next.out_red   = bts_pkg::OUT_W'(mix[0] >> SH);
            out_next.out_green = bts_pkg::OUT_W'(mix[1] >> SH);
            out_next.out_blue  = bts_pkg::OUT_W'(mix[2] >> SH);
        end else begin
            out_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl6_reg <= '0;
            ctl7_reg <= '0;
            ctl8_reg <= '0;
        end else if (adv) begin
            ctl6_reg <= ctl5;
            ctl7_reg <= ctl6_reg;
            ctl8_reg <= ctl7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fu6_reg  <= fu5;
            fv6_reg  <= fv5;
            top7_reg <= top_next;
            bot7_reg <= bot_next;
            fv7_reg  <= fv6_reg;
            out8_reg <= out_next;
        end
    end

    assign res_valid = ctl8_reg.valid && ctl8_reg.sample;
    assign res_data  = out8_reg;

endmodule

FILE: rtl/bilinear_texture_sampler.sv
// Bilinear texture sampler. One item per clock while s_ready is high: a texel
// write (cmd 0) or a sample (cmd 1). Items flow through an eight-stage
// pipeline (wrap, scale, index, two stages of address reduction, texel read,
// horizontal blend, vertical blend) into an output register. The texture is
// held twice, each copy a RAM with one write and two read ports, which gives
// the four texel reads per sample; an in-range write lands in both copies in
// the read stage, so it is seen by every later sample. A skid stage behind
// the output register lets the pipeline keep accepting while one result
// waits; s_ready drops only when both hold a result. Set tex_width,
// tex_height and texture_ready only while no item is in flight.
`include "assert_macros.svh"

module bilinear_texture_sampler #(
    parameter int MAX_DIM     = bts_pkg::MAX_DIM_DEF,
    parameter int TEXEL_DEPTH = bts_pkg::TEXEL_DEPTH_DEF,
    parameter int WEIGHT_BITS = bts_pkg::WEIGHT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bts_pkg::bts_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bts_pkg::bts_out_t                 m_data,
    input  logic                              cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bts_pkg::DIM_REG_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(TEXEL_DEPTH);

    logic [bts_pkg::DIM_REG_W-1:0] tex_width_reg;
    logic [bts_pkg::DIM_REG_W-1:0] tex_height_reg;
    logic                          texture_ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_reg     <= bts_pkg::DIM_REG_W'(1);
            tex_height_reg    <= bts_pkg::DIM_REG_W'(1);
            texture_ready_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                bts_pkg::CFG_TEX_WIDTH: begin
                    tex_width_reg <= cfg_wdata;
                end
                bts_pkg::CFG_TEX_HEIGHT: begin
                    tex_height_reg <= cfg_wdata;
                end
                bts_pkg::CFG_TEXTURE_READY: begin
                    texture_ready_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    logic                                adv;
    bts_pkg::bts_ctl_t                   ctl5;
    logic [3:0][AW-1:0]                  raddr5;
    logic [AW-1:0]                       waddr5;
    logic [bts_pkg::TEXEL_W-1:0]         texel5;
    logic [WEIGHT_BITS-1:0]              fu5, fv5;
    logic [3:0][bts_pkg::TEXEL_W-1:0]    rdata;
    logic                                ram_we;
    logic                                res_valid;
    bts_pkg::bts_out_t                   res_data;

    logic              skid_valid_reg;
    bts_pkg::bts_out_t skid_data_reg;
    logic              m_valid_reg;
    bts_pkg::bts_out_t m_data_reg;

    assign adv     = !skid_valid_reg;
    assign s_ready = adv;
    assign ram_we  = adv && ctl5.valid && !ctl5.sample && ctl5.wr_ok;

    bts_addr #(
        .MAX_DIM     (MAX_DIM),
        .TEXEL_DEPTH (TEXEL_DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_addr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .s_valid    (s_valid),
        .s_data     (s_data),
        .tex_width  (tex_width_reg),
        .tex_height (tex_height_reg),
        .ctl5       (ctl5),
        .raddr5     (raddr5),
        .waddr5     (waddr5),
        .texel5     (texel5),
        .fu5        (fu5),
        .fv5        (fv5)
    );

    bts_ram #(
        .WIDTH (bts_pkg::TEXEL_W),
        .DEPTH (TEXEL_DEPTH)
    ) u_ram_top (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (waddr5),
        .wdata   (texel5),
        .re      (adv),
        .raddr_a (raddr5[0]),
        .raddr_b (raddr5[1]),
        .rdata_a (rdata[0]),
        .rdata_b (rdata[1])
    );

    bts_ram #(
        .WIDTH (bts_pkg::TEXEL_W),
        .DEPTH (TEXEL_DEPTH)
    ) u_ram_bot (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (waddr5),
        .wdata   (texel5),
        .re      (adv),
        .raddr_a (raddr5[2]),
        .raddr_b (raddr5[3]),
        .rdata_a (rdata[2]),
        .rdata_b (rdata[3])
    );

    bts_blend #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .tex_ready (texture_ready_reg),
        .ctl5      (ctl5),
        .fu5       (fu5),
        .fv5       (fv5),
        .rdata     (rdata),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (res_valid && adv) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && adv) begin
            if (!m_valid_reg || m_ready) begin
                m_data_reg <= res_data;
            end else begin
                skid_data_reg <= res_data;
            end
        end else if (m_ready && skid_valid_reg) begin
            m_data_reg <= skid_data_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BTS_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_valid_reg, m_valid_reg, "skid full with output empty")
    `BTS_ASSERT_NXT(a_stall_to_skid, aclk, aresetn, m_valid_reg && !m_ready && res_valid && adv, skid_valid_reg, "result lost on stall")
    `BTS_ASSERT_NXT(a_skid_holds, aclk, aresetn, skid_valid_reg && !m_ready, skid_valid_reg && $stable(skid_data_reg), "skid changed while stalled")

endmodule
